### design/fscc_pkg.sv
`default_nettype none

package fscc_pkg;

    // Store sizes
    localparam int FLASH_BYTES  = 131072;
    localparam int SECTOR_BYTES = 4096;
    localparam int SRAM_BYTES   = 65536;
    localparam int BANK_AW      = 16;
    localparam int FLASH_AW     = $clog2(FLASH_BYTES);
    localparam int SRAM_AW      = $clog2(SRAM_BYTES);
    localparam int SECTOR_AW    = $clog2(SECTOR_BYTES);

    // Field widths
    localparam int OFFSET_W  = 25;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Unlock sequence
    localparam logic [OFFSET_W-1:0] ADDR_UNLOCK1 = 25'h5555;
    localparam logic [OFFSET_W-1:0] ADDR_UNLOCK2 = 25'h2AAA;
    localparam logic [OFFSET_W-1:0] ADDR_MAKER   = 25'h0;
    localparam logic [OFFSET_W-1:0] ADDR_DEVICE  = 25'h1;
    localparam logic [BYTE_W-1:0]   UNLOCK1_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0]   UNLOCK2_BYTE = 8'h55;

    // Flash command bytes
    localparam logic [BYTE_W-1:0] FCMD_CHIP_ERASE   = 8'h10;
    localparam logic [BYTE_W-1:0] FCMD_SECTOR_ERASE = 8'h30;
    localparam logic [BYTE_W-1:0] FCMD_ERASE        = 8'h80;
    localparam logic [BYTE_W-1:0] FCMD_ID_ON        = 8'h90;
    localparam logic [BYTE_W-1:0] FCMD_PROGRAM      = 8'hA0;
    localparam logic [BYTE_W-1:0] FCMD_BANK         = 8'hB0;
    localparam logic [BYTE_W-1:0] FCMD_ID_OFF       = 8'hF0;

    localparam logic [BYTE_W-1:0] ERASED_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] MAKER_ID_RST  = 8'h62;
    localparam logic [BYTE_W-1:0] DEVICE_ID_RST = 8'h13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAKER_ID  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 1'd1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ERASE,
        MODE_PROGRAM,
        MODE_BANK
    } t_mode;

    // Where a result byte comes from
    typedef enum logic [1:0] {
        RSRC_BYTE,
        RSRC_FLASH,
        RSRC_SRAM
    } t_rsrc;

    typedef struct packed {
        logic                we;
        logic                re;
        logic [FLASH_AW-1:0] addr;
        logic [BYTE_W-1:0]   wdata;
    } t_flash_req;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [SRAM_AW-1:0] addr;
        logic [BYTE_W-1:0]  wdata;
    } t_sram_req;

    typedef struct packed {
        t_rsrc             src;
        logic [BYTE_W-1:0] rbyte;
        logic              dirty;
        logic              active;
    } t_rd_info;

    function automatic logic [FLASH_AW-1:0] flash_index(input logic bank,
                                                        input logic [BANK_AW-1:0] off);
        logic [BANK_AW:0] full;
        full = {bank, off};
        return full[FLASH_AW-1:0];
    endfunction

endpackage

`default_nettype wire

### design/fscc_ram.sv
`default_nettype none

module fscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/fscc_ctrl.sv
`default_nettype none

module fscc_ctrl import fscc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_go,
    input  wire logic                 i_cmd,
    input  wire logic [OFFSET_W-1:0]  i_offset,
    input  wire logic [BYTE_W-1:0]    i_wdata,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTE_W-1:0]    i_cfg_wdata,
    output t_flash_req                o_flash,
    output t_sram_req                 o_sram,
    output t_rd_info                  o_info,
    output logic                      o_busy
);

    t_mode               r_mode, n_mode;
    logic                r_id, n_id;
    logic                r_fiu, n_fiu;
    logic                r_bank, n_bank;
    logic [BYTE_W-1:0]   r_maker, r_device;
    logic [BYTE_W-1:0]   r_sh_a, r_sh_b;   // shadow bytes at 0x5555 / 0x2AAA
    logic                r_clr, r_clr_sram;
    logic [FLASH_AW-1:0] r_clr_addr, r_clr_last;

    logic                is_wr, is_rd, unlock;
    logic                prog, chip, sector;
    logic [FLASH_AW-1:0] idx, sec_start;

    assign is_wr  = i_go && (i_cmd == CMD_WRITE);
    assign is_rd  = i_go && (i_cmd == CMD_READ);
    assign unlock = (r_sh_a == UNLOCK1_BYTE) && (r_sh_b == UNLOCK2_BYTE);
    assign idx    = flash_index(r_bank, i_offset[BANK_AW-1:0]);
    assign sec_start = flash_index(r_bank,
                           {i_offset[BANK_AW-1:SECTOR_AW], {SECTOR_AW{1'b0}}});
    assign o_busy = r_clr;

    // command decode
    always_comb begin
        n_mode = r_mode;
        n_id   = r_id;
        n_fiu  = r_fiu;
        n_bank = r_bank;
        prog   = 1'b0;
        chip   = 1'b0;
        sector = 1'b0;
        if (is_wr) begin
            if (r_mode == MODE_PROGRAM) begin
                prog   = 1'b1;
                n_mode = MODE_IDLE;
            end else if (r_mode == MODE_BANK && i_offset == '0) begin
                n_bank = i_wdata[0];
                n_mode = MODE_IDLE;
            end else if (unlock) begin
                if (i_offset == ADDR_UNLOCK1) begin
                    unique case (i_wdata)
                        FCMD_CHIP_ERASE: begin
                            if (r_mode == MODE_ERASE) begin
                                chip   = 1'b1;
                                n_mode = MODE_IDLE;
                            end
                        end
                        FCMD_ERASE:   n_mode = MODE_ERASE;
                        FCMD_ID_ON:   n_id   = 1'b1;
                        FCMD_PROGRAM: n_mode = MODE_PROGRAM;
                        FCMD_BANK:    n_mode = MODE_BANK;
                        FCMD_ID_OFF:  n_id   = 1'b0;
                        default: ;
                    endcase
                    if (n_mode != MODE_IDLE || n_id) begin
                        n_fiu = 1'b1;
                    end
                end else if (r_mode == MODE_ERASE && i_wdata == FCMD_SECTOR_ERASE) begin
                    sector = 1'b1;
                    n_mode = MODE_IDLE;
                end
            end
        end
    end

    // memory requests; the clear sweep owns both ports while running
    always_comb begin
        o_flash = '{we: 1'b0, re: 1'b0, addr: idx, wdata: i_wdata};
        o_sram  = '{we: 1'b0, re: 1'b0, addr: i_offset[SRAM_AW-1:0], wdata: i_wdata};
        if (r_clr) begin
            o_flash.we    = 1'b1;
            o_flash.addr  = r_clr_addr;
            o_flash.wdata = ERASED_BYTE;
            o_sram.we     = r_clr_sram && ((r_clr_addr >> SRAM_AW) == '0);
            o_sram.addr   = r_clr_addr[SRAM_AW-1:0];
            o_sram.wdata  = '0;
        end else begin
            o_flash.we = prog;
            o_flash.re = is_rd && !r_id && r_fiu;
            o_sram.we  = is_wr;
            o_sram.re  = is_rd && !r_id && !r_fiu;
        end
    end

    // result description, resolved once read data returns
    always_comb begin
        o_info.dirty  = i_cmd;
        o_info.active = n_fiu;
        o_info.rbyte  = '0;
        o_info.src    = RSRC_BYTE;
        if (i_cmd == CMD_READ) begin
            if (r_id) begin
                if (i_offset == ADDR_MAKER) begin
                    o_info.rbyte = r_maker;
                end else if (i_offset == ADDR_DEVICE) begin
                    o_info.rbyte = r_device;
                end
            end else if (r_fiu) begin
                o_info.src = RSRC_FLASH;
            end else begin
                o_info.src = RSRC_SRAM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_id       <= 1'b0;
            r_fiu      <= 1'b0;
            r_bank     <= 1'b0;
            r_maker    <= MAKER_ID_RST;
            r_device   <= DEVICE_ID_RST;
            r_sh_a     <= '0;
            r_sh_b     <= '0;
            r_clr      <= 1'b1;
            r_clr_sram <= 1'b1;
            r_clr_addr <= '0;
            r_clr_last <= '1;
        end else begin
            r_mode <= n_mode;
            r_id   <= n_id;
            r_fiu  <= n_fiu;
            r_bank <= n_bank;
            if (i_cfg_we && i_cfg_idx == CFG_MAKER_ID) begin
                r_maker <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_idx == CFG_DEVICE_ID) begin
                r_device <= i_cfg_wdata;
            end
            if (is_wr && i_offset[SRAM_AW-1:0] == ADDR_UNLOCK1[SRAM_AW-1:0]) begin
                r_sh_a <= i_wdata;
            end
            if (is_wr && i_offset[SRAM_AW-1:0] == ADDR_UNLOCK2[SRAM_AW-1:0]) begin
                r_sh_b <= i_wdata;
            end
            if (r_clr) begin
                if (r_clr_addr == r_clr_last) begin
                    r_clr      <= 1'b0;
                    r_clr_sram <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end else if (chip) begin
                r_clr      <= 1'b1;
                r_clr_sram <= 1'b0;
                r_clr_addr <= '0;
                r_clr_last <= '1;
            end else if (sector) begin
                r_clr      <= 1'b1;
                r_clr_sram <= 1'b0;
                r_clr_addr <= sec_start;
                r_clr_last <= sec_start | FLASH_AW'(SECTOR_BYTES - 1);
            end
        end
    end

    a_no_go_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !i_go)
        else $error("request taken during clear sweep");

    a_flash_port_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_flash.we && o_flash.re))
        else $error("flash read and write in one cycle");

    a_fiu_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fiu |=> r_fiu)
        else $error("flash in use dropped");

    a_program_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_wr && r_mode == MODE_PROGRAM) |=> (r_mode == MODE_IDLE))
        else $error("program mode not left after one byte");

endmodule

`default_nettype wire

### design/flash_save_command_controller_top.sv
`default_nettype none

// Byte-access save controller: each request is one read or write of the save
// region and yields exactly one response. State lives in two synchronous
// memories, a 64 KiB SRAM shadow and a two-bank flash array, plus a few mode
// bits; unlock writes (0xAA at 0x5555, 0x55 at 0x2AAA) followed by a command
// byte at 0x5555 drive erase, ID, program and bank switch. Throughput is one
// request per cycle while no sweep runs and the response path is not stalled;
// m_axis_tvalid rises once the request has passed the memory read, which
// registers on the accepting edge, and the output register, which loads
// when free. After reset both memories are swept, one entry per cycle,
// over all FLASH_BYTES = 131072 flash entries with s_axis_tready low, as
// during a chip erase (whole flash) or sector erase (SECTOR_BYTES = 4096).
// Configuration writes are taken at any time.

module flash_save_command_controller_top import fscc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [39:0]          s_axis_tdata,   // [24:0] offset, [32:25] wdata
    input  wire logic                 s_axis_tuser,   // [0] cmd
    // response channel
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [7:0] rdata
    output logic [1:0]                m_axis_tuser,   // [0] save_dirty, [1] flash_active
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTE_W-1:0]    i_cfg_wdata
);

    t_flash_req        flash_req;
    t_sram_req         sram_req;
    t_rd_info          info;
    logic              busy;
    logic              go, out_free;
    logic [BYTE_W-1:0] flash_rdata, sram_rdata, sel_byte;

    // stage 1: request in flight while memory read returns
    logic              r_pend;
    t_rd_info          r_pend_info;
    // stage 2: output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic [1:0]        r_out_user;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !busy && (!r_pend || out_free);
    assign go            = s_axis_tvalid && s_axis_tready;

    fscc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_cmd       (s_axis_tuser),
        .i_offset    (s_axis_tdata[OFFSET_W-1:0]),
        .i_wdata     (s_axis_tdata[OFFSET_W+BYTE_W-1:OFFSET_W]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_flash     (flash_req),
        .o_sram      (sram_req),
        .o_info      (info),
        .o_busy      (busy)
    );

    fscc_ram #(.WIDTH(BYTE_W), .DEPTH(FLASH_BYTES)) u_flash_ram (
        .i_clk   (i_clk),
        .i_we    (flash_req.we),
        .i_re    (flash_req.re),
        .i_addr  (flash_req.addr),
        .i_wdata (flash_req.wdata),
        .o_rdata (flash_rdata)
    );

    fscc_ram #(.WIDTH(BYTE_W), .DEPTH(SRAM_BYTES)) u_sram_ram (
        .i_clk   (i_clk),
        .i_we    (sram_req.we),
        .i_re    (sram_req.re),
        .i_addr  (sram_req.addr),
        .i_wdata (sram_req.wdata),
        .o_rdata (sram_rdata)
    );

    // pick the response byte; memory outputs hold while a response waits
    always_comb begin
        case (r_pend_info.src)
            RSRC_FLASH: sel_byte = flash_rdata;
            RSRC_SRAM:  sel_byte = sram_rdata;
            default:    sel_byte = r_pend_info.rbyte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                r_pend <= 1'b1;
            end else if (r_pend && out_free) begin
                r_pend <= 1'b0;
            end
            if (r_pend && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_pend_info <= info;
        end
        if (r_pend && out_free) begin
            r_out_data <= sel_byte;
            r_out_user <= {r_pend_info.active, r_pend_info.dirty};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

### tb/sv/fscc_save_checker.sv
`timescale 1ns / 100ps

module fscc_save_checker import fscc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    input  wire logic                 i_req_ready,
    input  wire logic [39:0]          i_req_data,   // [24:0] offset, [32:25] wdata
    input  wire logic                 i_req_user,   // [0] cmd
    input  wire logic                 i_rsp_valid,
    input  wire logic                 i_rsp_ready,
    input  wire logic [7:0]           i_rsp_data,   // [7:0] rdata
    input  wire logic [1:0]           i_rsp_user,   // [0] save_dirty, [1] flash_active
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTE_W-1:0]    i_cfg_wdata,
    output int                        o_errors,
    output int                        o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] rdata;
        logic              dirty;
        logic              active;
    } t_save_resp;

    logic [BYTE_W-1:0] sram_img  [SRAM_BYTES];
    logic [BYTE_W-1:0] flash_img [FLASH_BYTES];
    t_mode             mode_q;
    logic              id_on;
    logic              in_use;
    logic              bank_q;
    logic [BYTE_W-1:0] maker_q;
    logic [BYTE_W-1:0] device_q;
    t_save_resp        resp_q [$];
    int                err_cnt;

    function automatic int flash_addr(input logic [15:0] off16);
        return int'({bank_q, off16}) & (FLASH_BYTES - 1);
    endfunction

    function automatic logic [BYTE_W-1:0] read_byte(input logic [OFFSET_W-1:0] off);
        if (id_on) begin
            if (off == ADDR_MAKER) return maker_q;
            if (off == ADDR_DEVICE) return device_q;
            return '0;
        end
        if (in_use) return flash_img[flash_addr(off[15:0])];
        return sram_img[off[15:0]];
    endfunction

    // Command decode, then the shadow store. Unlock check sees the shadow
    // as it was before this byte lands.
    task automatic apply_write(input logic [OFFSET_W-1:0] off, input logic [BYTE_W-1:0] val);
        logic [15:0] base;
        if (mode_q == MODE_PROGRAM) begin
            flash_img[flash_addr(off[15:0])] = val;
            mode_q = MODE_IDLE;
        end else if (mode_q == MODE_BANK && off == ADDR_MAKER) begin
            bank_q = val[0];
            mode_q = MODE_IDLE;
        end else if (sram_img[ADDR_UNLOCK1[15:0]] == UNLOCK1_BYTE &&
                     sram_img[ADDR_UNLOCK2[15:0]] == UNLOCK2_BYTE) begin
            if (off == ADDR_UNLOCK1) begin
                case (val)
                    FCMD_CHIP_ERASE: begin
                        if (mode_q == MODE_ERASE) begin
                            foreach (flash_img[i]) flash_img[i] = ERASED_BYTE;
                            mode_q = MODE_IDLE;
                        end
                    end
                    FCMD_ERASE:   mode_q = MODE_ERASE;
                    FCMD_ID_ON:   id_on = 1'b1;
                    FCMD_PROGRAM: mode_q = MODE_PROGRAM;
                    FCMD_BANK:    mode_q = MODE_BANK;
                    FCMD_ID_OFF:  id_on = 1'b0;
                    default: ;
                endcase
                if (mode_q != MODE_IDLE || id_on) in_use = 1'b1;
            end else if (mode_q == MODE_ERASE && val == FCMD_SECTOR_ERASE) begin
                base = off[15:0] & ~16'(SECTOR_BYTES - 1);
                for (int i = 0; i < SECTOR_BYTES; i++)
                    flash_img[flash_addr(base + 16'(i))] = ERASED_BYTE;
                mode_q = MODE_IDLE;
            end
        end
        sram_img[off[15:0]] = val;
    endtask

    always @(posedge i_clk) begin
        t_save_resp want;
        t_save_resp got;
        if (!i_rst_n) begin
            foreach (sram_img[i]) sram_img[i] = '0;
            foreach (flash_img[i]) flash_img[i] = ERASED_BYTE;
            mode_q   = MODE_IDLE;
            id_on    = 1'b0;
            in_use   = 1'b0;
            bank_q   = 1'b0;
            maker_q  = MAKER_ID_RST;
            device_q = DEVICE_ID_RST;
            resp_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAKER_ID:  maker_q = i_cfg_wdata;
                    CFG_DEVICE_ID: device_q = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got = '{rdata: i_rsp_data, dirty: i_rsp_user[0], active: i_rsp_user[1]};
                if (resp_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: response with no request outstanding: rdata %02h dirty %b active %b",
                             $time, got.rdata, got.dirty, got.active);
                end else begin
                    want = resp_q.pop_front();
                    if (got.rdata !== want.rdata) begin
                        err_cnt++;
                        $display("%0t: rdata expected %02h actual %02h",
                                 $time, want.rdata, got.rdata);
                    end
                    if (got.dirty !== want.dirty) begin
                        err_cnt++;
                        $display("%0t: save_dirty expected %b actual %b",
                                 $time, want.dirty, got.dirty);
                    end
                    if (got.active !== want.active) begin
                        err_cnt++;
                        $display("%0t: flash_active expected %b actual %b",
                                 $time, want.active, got.active);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_user == CMD_WRITE) begin
                    apply_write(i_req_data[OFFSET_W-1:0], i_req_data[OFFSET_W +: BYTE_W]);
                    want.rdata = '0;
                    want.dirty = 1'b1;
                end else begin
                    want.rdata = read_byte(i_req_data[OFFSET_W-1:0]);
                    want.dirty = 1'b0;
                end
                want.active = in_use;
                resp_q.push_back(want);
            end
        end
        o_errors  <= err_cnt;
        o_pending <= resp_q.size();
    end

endmodule

### tb/sv/flash_save_command_controller_top_tb.sv
`timescale 1ns / 100ps

module flash_save_command_controller_top_tb import fscc_pkg::*;;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 1200;
    // Slowest legal run: reset sweep, up to CHIP_ERASE_CAP chip erases (whole
    // flash each), up to SECTOR_ERASE_CAP sector erases (one sector each), and
    // every request taking a long sender gap plus a long receiver stall;
    // CYCLE_LIMIT sits well above that.
    localparam int CYCLE_LIMIT      = 4_000_000;
    localparam int CHIP_ERASE_CAP   = 2;
    localparam int SECTOR_ERASE_CAP = 60;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic [39:0]          s_axis_tdata  = '0;     // [24:0] offset, [32:25] wdata
    logic                 s_axis_tuser  = CMD_READ; // [0] cmd
    logic                 m_axis_tready = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_MAKER_ID;
    logic [BYTE_W-1:0]    i_cfg_wdata   = '0;

    wire logic            s_axis_tready;
    wire logic            m_axis_tvalid;
    wire logic [7:0]      m_axis_tdata;           // [7:0] rdata
    wire logic [1:0]      m_axis_tuser;           // [0] save_dirty, [1] flash_active

    int errors;
    int pending;
    int sent_cnt      = 0;
    int cycle_cnt     = 0;
    int chip_erases   = 0;
    int sector_erases = 0;
    bit no_idle       = 1'b0;   // both sides run back to back while set

    flash_save_command_controller_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // Predicts every response and compares; we only see its error and
    // outstanding-response counts.
    fscc_save_checker u_save_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(s_axis_tvalid),
        .i_req_ready(s_axis_tready),
        .i_req_data (s_axis_tdata),
        .i_req_user (s_axis_tuser),
        .i_rsp_valid(m_axis_tvalid),
        .i_rsp_ready(m_axis_tready),
        .i_rsp_data (m_axis_tdata),
        .i_rsp_user (m_axis_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a stuck erase ends here.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Idle length: mostly short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offsets: command/ID addresses, a small hot area that keeps hitting
    // programmed and erased bytes, any 16-bit offset, or fully random with
    // high bits set (only spoils exact matches).
    function automatic logic [OFFSET_W-1:0] pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 4))
                0: return ADDR_MAKER;
                1: return ADDR_DEVICE;
                2: return ADDR_UNLOCK1;
                3: return ADDR_UNLOCK2;
                default: return OFFSET_W'(16'hFFFF);
            endcase
        end
        if (r < 50) return OFFSET_W'(($urandom_range(0, 3) << 12) | $urandom_range(0, 15));
        if (r < 85) return OFFSET_W'($urandom_range(0, 16'hFFFF));
        return OFFSET_W'($urandom());
    endfunction

    // Response side: random stalls unless no_idle is set.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (no_idle || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                stall = pick_gap() - 1;
            end
        end
    end

    // One request; valid stays high into the next request when no gap follows.
    task automatic send_req(input logic is_wr, input logic [OFFSET_W-1:0] off,
                            input logic [BYTE_W-1:0] val);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, val, off};
        s_axis_tuser  <= is_wr;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_cnt++;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic unlock();
        send_req(CMD_WRITE, ADDR_UNLOCK1, UNLOCK1_BYTE);
        send_req(CMD_WRITE, ADDR_UNLOCK2, UNLOCK2_BYTE);
    endtask

    task automatic flash_cmd(input logic [BYTE_W-1:0] code);
        unlock();
        send_req(CMD_WRITE, ADDR_UNLOCK1, code);
    endtask

    // Hold off requests until every response is back.
    task automatic drain_responses();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // ID registers are only written with the block quiet.
    task automatic write_ids(input logic [BYTE_W-1:0] maker, input logic [BYTE_W-1:0] device);
        drain_responses();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_MAKER_ID;
        i_cfg_wdata <= maker;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_DEVICE_ID;
        i_cfg_wdata <= device;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One random sequence: mostly well-formed command sequences with random
    // payload, the rest plain accesses and broken unlocks.
    task automatic random_seq();
        int                  r;
        logic [OFFSET_W-1:0] off;
        logic [BYTE_W-1:0]   val;
        r   = $urandom_range(0, 99);
        off = pick_offset();
        val = BYTE_W'($urandom_range(0, 255));
        if (r < 25) begin
            send_req(1'($urandom_range(0, 1)), off, val);
        end else if (r < 35) begin
            send_req(CMD_READ, off, val);
        end else if (r < 45) begin
            flash_cmd($urandom_range(0, 1) ? FCMD_ID_ON : FCMD_ID_OFF);
            send_req(CMD_READ, ADDR_MAKER, val);
            send_req(CMD_READ, ($urandom_range(0, 3) == 0) ? off : ADDR_DEVICE, val);
        end else if (r < 63) begin
            flash_cmd(FCMD_PROGRAM);
            send_req(CMD_WRITE, off, val);
            send_req(CMD_READ, off, ~val);
        end else if (r < 72) begin
            // bank switch; now and then the follow-up misses offset 0
            flash_cmd(FCMD_BANK);
            send_req(CMD_WRITE, ($urandom_range(0, 9) == 0) ? off : ADDR_MAKER, val);
        end else if (r < 84) begin
            flash_cmd(FCMD_ERASE);
            if (chip_erases < CHIP_ERASE_CAP && $urandom_range(0, 29) == 0) begin
                chip_erases++;
                flash_cmd(FCMD_CHIP_ERASE);
            end else if (sector_erases < SECTOR_ERASE_CAP && $urandom_range(0, 3) != 0) begin
                sector_erases++;
                unlock();
                send_req(CMD_WRITE, off, FCMD_SECTOR_ERASE);
            end
            send_req(CMD_READ, off, val);
        end else if (r < 92) begin
            // any byte: unknown codes, stray chip-erase confirm, etc.
            flash_cmd(val);
        end else begin
            // broken unlock: second byte wrong or missing
            send_req(CMD_WRITE, ADDR_UNLOCK1, UNLOCK1_BYTE);
            if ($urandom_range(0, 1)) send_req(CMD_WRITE, ADDR_UNLOCK2, val);
            send_req(CMD_WRITE, ADDR_UNLOCK1, $urandom_range(0, 1) ? FCMD_PROGRAM : FCMD_ID_ON);
        end
    endtask

    initial begin
        int target;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: SRAM path first, including high offset bits
        send_req(CMD_READ, ADDR_MAKER, 8'h00);
        send_req(CMD_WRITE, 25'h1FFFFFF, 8'hFF);
        send_req(CMD_READ, 25'h000FFFF, 8'h00);
        // ID mode with reset IDs, high bits spoil the ID match
        flash_cmd(FCMD_ID_ON);
        send_req(CMD_READ, ADDR_MAKER, 8'h00);
        send_req(CMD_READ, 25'h1000001, 8'h00);
        write_ids(8'hFF, 8'h00);
        send_req(CMD_READ, ADDR_DEVICE, 8'hFF);
        flash_cmd(FCMD_ID_OFF);
        // program ignores high offset bits, then sector erase wipes it
        flash_cmd(FCMD_PROGRAM);
        send_req(CMD_WRITE, 25'h1FF1234, 8'h00);
        send_req(CMD_READ, 25'h0001234, 8'hFF);
        flash_cmd(FCMD_ERASE);
        unlock();
        send_req(CMD_WRITE, 25'h0001ABC, FCMD_SECTOR_ERASE);
        send_req(CMD_READ, 25'h0001234, 8'h00);
        // bank 1, program there, then chip erase
        flash_cmd(FCMD_BANK);
        send_req(CMD_WRITE, ADDR_MAKER, 8'h01);
        flash_cmd(FCMD_PROGRAM);
        send_req(CMD_WRITE, ADDR_MAKER, 8'h5A);
        flash_cmd(FCMD_ERASE);
        flash_cmd(FCMD_CHIP_ERASE);
        send_req(CMD_READ, ADDR_MAKER, 8'h00);

        // Random phases, each with its own ID setting; phase 2 runs with no
        // idling on either side.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_ids(8'h00, 8'hFF);
                2: write_ids(MAKER_ID_RST, DEVICE_ID_RST);
                default: write_ids(BYTE_W'($urandom_range(0, 255)),
                                   BYTE_W'($urandom_range(0, 255)));
            endcase
            no_idle = (ph == 2);
            target  = sent_cnt + RANDOM_ITEMS / 4;
            while (sent_cnt < target) random_seq();
        end

        drain_responses();
        // response path is two deep; give stray beats time to show up
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
